### rtl/core/tcw_pkg.sv
// Package for the text console writer: payload types, operation codes and
// cell constants shared by the interfaces, the core and the checker.
// No dependencies.
`default_nettype none

package tcw_pkg;

  // Field widths of the request and response payloads
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int DATA_W = 16;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Cell constants
  localparam logic [DATA_W-1:0] ATTR_NORMAL  = 16'h0700;
  localparam logic [DATA_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  // Operation codes; code 3 is unused and does nothing
  typedef enum logic [OP_W-1:0] {
    OP_PUT  = 2'd0,
    OP_READ = 2'd1,
    OP_SET  = 2'd2
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [IDX_W-1:0]  cursor_position;
    logic              cursor_updated;
    logic              scrolled;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/core/tcw_if.sv
// Valid/ready channel interfaces for the console request and response.
// Depends on tcw_pkg for the payload types.
`default_nettype none

interface tcw_req_if;
  logic          valid;
  logic          ready;
  tcw_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcw_rsp_if;
  logic          valid;
  logic          ready;
  tcw_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/tcw_alu.sv
// Shared add/subtract unit with a magnitude compare, used by the sequencer
// for cursor advance, line-start search and the scroll cursor fix-up.
// No dependencies.
`default_nettype none

module tcw_alu #(
  parameter int W = 12
) (
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  input  wire logic [W-1:0] c_i,
  input  wire logic         sub_i,
  output logic      [W-1:0] res_o,
  output logic              gt_o
);

  // a +/- b, and a > c
  assign res_o = sub_i ? (a_i - b_i) : (a_i + b_i);
  assign gt_o  = (a_i > c_i);

endmodule

`default_nettype wire

### rtl/core/text_console_writer.sv
// Text console writer: a COLUMNS x ROWS store of 16-bit cells (attribute high,
// character low) driven by put-character, read-cell and set-cursor requests,
// one response per request. After reset a clearing pass writes blank cells
// into the store, one cell a cycle, during which no request is taken. Set and
// a plain character that does not scroll go straight to the response state;
// a read first waits for the registered store data. A newline searches for
// the next line start with the shared adder, one row per cycle. A character
// or newline that runs past the last cell scrolls: every cell below the top
// row is copied up one row through the single store write port, then the
// bottom row is blanked. The response sits in an output register; a new
// request is taken while it waits, but the next response waits for it.
// Depends on tcw_pkg, tcw_if, tcw_ram and tcw_alu.
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tcw_req_if.sink    req_i,
  tcw_rsp_if.source  rsp_o
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int CW = $clog2(CELL_COUNT + COLUMNS + 1);
  localparam int XW = (CW > tcw_pkg::IDX_W) ? CW : tcw_pkg::IDX_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NEWLINE,
    ST_READ,
    ST_COPY,
    ST_BLANK,
    ST_FINISH
  } state_e;

  state_e                      state_q, state_d;
  logic [CW-1:0]               cursor_q, cursor_d;
  logic [CW-1:0]               acc_q, acc_d;
  logic [CW-1:0]               src_q, src_d;
  logic [AW-1:0]               dst_q, dst_d;
  logic                        pend_q, pend_d;
  logic [tcw_pkg::DATA_W-1:0]  rdata_q, rdata_d;
  logic                        upd_q, upd_d;
  logic                        scr_q, scr_d;
  logic                        rsp_valid_q, rsp_valid_d;
  tcw_pkg::rsp_t               rsp_q, rsp_d;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [tcw_pkg::DATA_W-1:0]  ram_wdata, ram_rdata;

  logic [CW-1:0]               alu_a, alu_b, alu_c, alu_res;
  logic                        alu_sub, alu_gt;

  logic [XW-1:0]               idx_x;
  logic                        idx_ok;

  assign idx_x  = XW'(req_i.data.cell_index);
  assign idx_ok = (idx_x < XW'(CELL_COUNT));

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  tcw_ram #(
    .WIDTH (tcw_pkg::DATA_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tcw_alu #(
    .W (CW)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .c_i   (alu_c),
    .sub_i (alu_sub),
    .res_o (alu_res),
    .gt_o  (alu_gt)
  );

  // Sequencer next-state, store and adder control
  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    acc_d       = acc_q;
    src_d       = src_q;
    dst_d       = dst_q;
    pend_d      = pend_q;
    rdata_d     = rdata_q;
    upd_d       = upd_q;
    scr_d       = scr_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;

    ram_we    = 1'b0;
    ram_waddr = dst_q;
    ram_wdata = tcw_pkg::BLANK_CELL;
    ram_re    = 1'b0;
    ram_raddr = AW'(src_q);

    alu_a   = cursor_q;
    alu_b   = CW'(1);
    alu_c   = cursor_q;
    alu_sub = 1'b0;

    unique case (state_q)
      // Blank the store after reset
      ST_CLEAR: begin
        ram_we = 1'b1;
        dst_d  = dst_q + AW'(1);
        if (dst_q == AW'(CELL_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end

      // Take a request and start it
      ST_IDLE: begin
        if (req_i.valid) begin
          rdata_d = '0;
          upd_d   = 1'b0;
          scr_d   = 1'b0;
          unique case (req_i.data.operation)
            tcw_pkg::OP_PUT: begin
              if (req_i.data.char_code == tcw_pkg::NEWLINE_CODE) begin
                acc_d   = CW'(COLUMNS);
                upd_d   = 1'b1;
                state_d = ST_NEWLINE;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cursor_q);
                ram_wdata = tcw_pkg::ATTR_NORMAL |
                            tcw_pkg::DATA_W'(req_i.data.char_code);
                cursor_d  = alu_res;
                if (alu_res == CW'(CELL_COUNT)) begin
                  src_d   = CW'(COLUMNS);
                  dst_d   = '0;
                  pend_d  = 1'b0;
                  state_d = ST_COPY;
                end else begin
                  state_d = ST_FINISH;
                end
              end
            end
            tcw_pkg::OP_READ: begin
              if (idx_ok) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(idx_x);
                state_d   = ST_READ;
              end else begin
                state_d = ST_FINISH;
              end
            end
            tcw_pkg::OP_SET: begin
              if (idx_ok) begin
                cursor_d = CW'(idx_x);
              end
              state_d = ST_FINISH;
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end

      // Step a line start forward one row until it passes the cursor
      ST_NEWLINE: begin
        alu_a = acc_q;
        alu_b = CW'(COLUMNS);
        alu_c = cursor_q;
        if (alu_gt) begin
          cursor_d = acc_q;
          if (acc_q == CW'(CELL_COUNT)) begin
            src_d   = CW'(COLUMNS);
            dst_d   = '0;
            pend_d  = 1'b0;
            state_d = ST_COPY;
          end else begin
            state_d = ST_FINISH;
          end
        end else begin
          acc_d = alu_res;
        end
      end

      // Registered read data is ready
      ST_READ: begin
        rdata_d = ram_rdata;
        state_d = ST_FINISH;
      end

      // Scroll: read one row ahead, write the cell read last cycle
      ST_COPY: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          dst_d     = dst_q + AW'(1);
        end
        if (src_q < CW'(CELL_COUNT)) begin
          ram_re = 1'b1;
          src_d  = src_q + CW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (!pend_q && (src_q == CW'(CELL_COUNT))) begin
          state_d = ST_BLANK;
        end
      end

      // Blank the bottom row, then pull the cursor back one row
      ST_BLANK: begin
        ram_we = 1'b1;
        dst_d  = dst_q + AW'(1);
        if (dst_q == AW'(CELL_COUNT - 1)) begin
          alu_b    = CW'(COLUMNS);
          alu_sub  = 1'b1;
          cursor_d = alu_res;
          upd_d    = 1'b1;
          scr_d    = 1'b1;
          state_d  = ST_FINISH;
        end
      end

      // Load the response once the output register is free
      ST_FINISH: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d           = 1'b1;
          rsp_d.read_data       = rdata_q;
          rsp_d.cursor_position = tcw_pkg::IDX_W'(cursor_q);
          rsp_d.cursor_updated  = upd_q;
          rsp_d.scrolled        = scr_q;
          state_d               = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cursor_q    <= '0;
      dst_q       <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      dst_q       <= dst_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    src_q   <= src_d;
    rdata_q <= rdata_d;
    upd_q   <= upd_d;
    scr_q   <= scr_d;
    rsp_q   <= rsp_d;
  end

endmodule

`default_nettype wire

### rtl/core/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer.
`default_nettype none

module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_ready_i,
  input wire logic          out_valid_i,
  input wire logic          out_ready_i,
  input wire tcw_pkg::rsp_t out_data_i
);

  localparam int CELL_COUNT = COLUMNS * ROWS;

  // No response and no request taken while reset is asserted
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> (!out_valid_i && !in_ready_i))
    else $error("activity during reset");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled response changed");

  // Cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.cursor_position < CELL_COUNT))
    else $error("cursor off screen");

  // A scroll always rewrites the hardware cursor
  a_scroll_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_data_i.scrolled) |-> out_data_i.cursor_updated)
    else $error("scroll without cursor update");

  // Read data only comes with reads, which never move the cursor
  a_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_data_i.read_data != '0)) |->
      (!out_data_i.cursor_updated && !out_data_i.scrolled))
    else $error("read data on a cursor-moving response");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_data_i  (rsp_o.data)
);

`default_nettype wire

### verif/tb_text_console_writer.sv
// Testbench for text_console_writer: random and directed console requests with a
// cell-accurate scoreboard of the 80x25 store and the cursor.
// Depends on tcw_pkg, tcw_if and the text_console_writer RTL.
`timescale 1ns / 1ps

module tb_text_console_writer;

  localparam int COLS          = tcw_pkg::COLUMNS_DEF;
  localparam int LINES         = tcw_pkg::ROWS_DEF;
  localparam int CELLS         = COLS * LINES;
  localparam int IDX_MAX       = (1 << tcw_pkg::IDX_W) - 1;
  localparam int RANDOM_ITEMS  = 800;
  localparam int DRAIN_CYCLES  = 3 * CELLS;
  localparam int CYCLE_LIMIT   = 8_000_000;
  localparam int MAX_GAP       = 13;
  localparam logic [tcw_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // Tracks the screen store and cursor, queues the response due for each request
  class console_tracker;
    logic [tcw_pkg::DATA_W-1:0] cells [CELLS];
    int unsigned                cursor;
    tcw_pkg::rsp_t              pending_rsp [$];
    int                         mismatches;

    function new();
      for (int i = 0; i < CELLS; i++) cells[i] = tcw_pkg::BLANK_CELL;
      cursor     = 0;
      mismatches = 0;
    endfunction

    function void apply_request(tcw_pkg::req_t r);
      tcw_pkg::rsp_t want;
      want = '0;
      case (r.operation)
        tcw_pkg::OP_PUT: begin
          if (r.char_code == tcw_pkg::NEWLINE_CODE) begin
            cursor = cursor + COLS - cursor % COLS;
            want.cursor_updated = 1'b1;
          end else begin
            // byte is stored unsigned, no sign extension into the attribute
            cells[cursor] = tcw_pkg::ATTR_NORMAL | {8'h00, r.char_code};
            cursor++;
          end
          // ran past the last cell: shift rows up, blank the bottom row
          if (cursor >= CELLS) begin
            for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = tcw_pkg::BLANK_CELL;
            cursor -= COLS;
            want.scrolled       = 1'b1;
            want.cursor_updated = 1'b1;
          end
        end
        tcw_pkg::OP_READ:
          if (r.cell_index < CELLS) want.read_data = cells[r.cell_index];
        tcw_pkg::OP_SET:
          if (r.cell_index < CELLS) cursor = r.cell_index;
        default: ;
      endcase
      want.cursor_position = cursor[tcw_pkg::IDX_W-1:0];
      pending_rsp.push_back(want);
    endfunction

    function void compare_response(tcw_pkg::rsp_t got);
      tcw_pkg::rsp_t want;
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding: %h", got);
        mismatches++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %h, got %h", want.read_data, got.read_data);
        mismatches++;
      end
      if (got.cursor_position !== want.cursor_position) begin
        $error("cursor_position: expected %0d, got %0d",
               want.cursor_position, got.cursor_position);
        mismatches++;
      end
      if (got.cursor_updated !== want.cursor_updated) begin
        $error("cursor_updated: expected %b, got %b",
               want.cursor_updated, got.cursor_updated);
        mismatches++;
      end
      if (got.scrolled !== want.scrolled) begin
        $error("scrolled: expected %b, got %b", want.scrolled, got.scrolled);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_rsp.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   cycle_count = 0;

  tcw_req_if req_if ();
  tcw_rsp_if rsp_if ();

  console_tracker tracker = new();

  text_console_writer #(
    .COLUMNS (COLS),
    .ROWS    (LINES)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("text_console_writer regression: fail");
    $finish;
  end

  // Every fourth block of 48 items runs back to back, no idle cycles
  function automatic int draw_gap(int n);
    if ((n / 48) % 4 == 3) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic tcw_pkg::req_t make_req(logic [tcw_pkg::OP_W-1:0] op, int ch, int idx);
    tcw_pkg::req_t r;
    r.operation  = op;
    r.char_code  = ch[tcw_pkg::CHAR_W-1:0];
    r.cell_index = idx[tcw_pkg::IDX_W-1:0];
    return r;
  endfunction

  // Drive one request; valid stays high across back-to-back requests
  task automatic send_request(input tcw_pkg::req_t r, input int gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    tracker.apply_request(r);
    @(negedge clk_i);
  endtask

  // Response sink with random backpressure
  initial begin : rsp_sink
    int stall;
    int taken;
    taken = 0;
    rsp_if.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      stall = draw_gap(taken + 17);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      tracker.compare_response(rsp_if.data);
      taken++;
      @(negedge clk_i);
    end
  end

  // Stimulus
  initial begin : req_source
    tcw_pkg::req_t directed [$];
    tcw_pkg::req_t r;
    int   sel;
    int   ch;
    int   idx;
    int   n;

    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: blank store after reset, range edges, byte extremes, scrolls
    directed.push_back(make_req(tcw_pkg::OP_READ, 0, 0));
    directed.push_back(make_req(tcw_pkg::OP_READ, 255, CELLS - 1));
    directed.push_back(make_req(tcw_pkg::OP_READ, 0, CELLS));        // past the store
    directed.push_back(make_req(tcw_pkg::OP_READ, 0, IDX_MAX));
    directed.push_back(make_req(tcw_pkg::OP_PUT, 8'h41, 0));
    directed.push_back(make_req(tcw_pkg::OP_PUT, 8'hFF, IDX_MAX));   // high bit set
    directed.push_back(make_req(tcw_pkg::OP_PUT, 8'h80, 0));
    directed.push_back(make_req(tcw_pkg::OP_PUT, 8'h00, 0));
    directed.push_back(make_req(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 0));
    // newline at line start
    directed.push_back(make_req(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 0));
    directed.push_back(make_req(tcw_pkg::OP_READ, 0, 1));
    directed.push_back(make_req(tcw_pkg::OP_READ, 0, 2));
    directed.push_back(make_req(tcw_pkg::OP_SET, 0, CELLS - 1));
    directed.push_back(make_req(tcw_pkg::OP_PUT, 8'h7E, 0));         // last cell scrolls
    directed.push_back(make_req(tcw_pkg::OP_READ, 0, CELLS - COLS - 1));
    directed.push_back(make_req(tcw_pkg::OP_READ, 0, CELLS - 1));
    directed.push_back(make_req(tcw_pkg::OP_SET, 0, CELLS));         // ignored
    directed.push_back(make_req(tcw_pkg::OP_SET, 0, IDX_MAX));       // ignored
    directed.push_back(make_req(tcw_pkg::OP_SET, 0, CELLS - COLS));
    // newline on last row scrolls
    directed.push_back(make_req(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 0));
    directed.push_back(make_req(OP_UNUSED, 8'hFF, IDX_MAX));
    directed.push_back(make_req(tcw_pkg::OP_SET, 0, 0));
    directed.push_back(make_req(tcw_pkg::OP_READ, 0, 0));
    directed.push_back(make_req(tcw_pkg::OP_PUT, 8'h20, 0));
    directed.push_back(make_req(tcw_pkg::OP_READ, 0, 0));
    foreach (directed[i]) send_request(directed[i], draw_gap(i));

    // Random: mostly prints, with cursor moves biased toward the bottom rows
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      ch  = $urandom_range(0, 255);
      idx = $urandom_range(0, IDX_MAX);
      if (sel < 55) begin
        if ($urandom_range(0, 9) == 0) ch = tcw_pkg::NEWLINE_CODE;
        r = make_req(tcw_pkg::OP_PUT, ch, idx);
      end else if (sel < 80) begin
        if ($urandom_range(0, 7) != 0) idx = $urandom_range(0, CELLS - 1);
        r = make_req(tcw_pkg::OP_READ, ch, idx);
      end else if (sel < 96) begin
        case ($urandom_range(0, 5))
          0, 1:    idx = $urandom_range(CELLS - 2 * COLS, CELLS - 1);
          2:       idx = $urandom_range(CELLS, IDX_MAX);
          default: idx = $urandom_range(0, CELLS - 1);
        endcase
        r = make_req(tcw_pkg::OP_SET, ch, idx);
      end else begin
        r = make_req(OP_UNUSED, ch, idx);
      end
      send_request(r, draw_gap(n));
    end
    req_if.valid <= 1'b0;

    // Drain: wait for every response, then watch for strays through a scroll
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tracker.mismatches == 0) begin
      $display("text_console_writer regression: pass");
    end else begin
      $display("text_console_writer regression: fail");
    end
    $finish;
  end

endmodule
